// File: rtl/egcu_pkg.sv
`default_nettype none

package egcu_pkg;

  // cell states
  localparam logic [2:0] ST_EMPTY    = 3'd0;
  localparam logic [2:0] ST_HEALTHY  = 3'd1;
  localparam logic [2:0] ST_INFECTED = 3'd2;
  localparam logic [2:0] ST_IMMUNE   = 3'd3;
  localparam logic [2:0] ST_DEAD     = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROXIMITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEALTHY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMMUNE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEATH       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INF_LENGTH  = 3'd6;

  localparam logic [5:0] COUNT_MAX = 6'd63;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_COMMIT = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_LOAD   = 2'd1,
    RES_READ   = 2'd2,
    RES_UPDATE = 2'd3
  } res_sel_e;

  typedef enum logic [3:0] {
    S_IDLE       = 4'd0,
    S_DISPATCH   = 4'd1,
    S_CENTER     = 4'd2,
    S_SCAN       = 4'd3,
    S_DRAIN      = 4'd4,
    S_DECIDE     = 4'd5,
    S_COPY       = 4'd6,
    S_COPY_DRAIN = 4'd7,
    S_FINISH     = 4'd8
  } state_e;

  typedef struct packed {
    logic     capture;
    logic     load_wr;
    logic     center_rd;
    logic     latch_center;
    logic     scan_init;
    logic     scan_issue;
    logic     decide;
    logic     copy_init;
    logic     copy_issue;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic in_range;
    logic scan_last;
    logic copy_last;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/epidemic_grid_cell_update.sv
// Load and out-of-range requests go from dispatch to the result register; a read first
//   fetches the centre; an update also scans the (2r+1)^2 square, r the effective radius.
// One request at a time; the next is accepted once the result sits in the output register.
// Update rate is set by the single read port of the current grid, one neighbour per cycle.
// Commit is a copy sweep through the shadow grid, one cell per cycle.
// Reset clears control and configuration only; grid memories hold nothing until written.
`default_nettype none

module epidemic_grid_cell_update import egcu_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [5:0]            row_i,
  input  wire logic [5:0]            column_i,
  input  wire logic [2:0]            cell_value_i,
  input  wire logic [7:0]            countdown_value_i,
  input  wire logic [6:0]            chance_draw_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [2:0]                 cell_result_o,
  output logic [7:0]                 countdown_result_o,
  output logic [5:0]                 infected_nearby_o
);

  // controller sequences dispatch, neighbour scan and commit sweep;
  // datapath owns the three grid memories, the config and the result registers
  cmd_t cmd;
  sts_t sts;

  egcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  egcu_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .row_i              (row_i),
    .column_i           (column_i),
    .cell_value_i       (cell_value_i),
    .countdown_value_i  (countdown_value_i),
    .chance_draw_i      (chance_draw_i),
    .cell_result_o      (cell_result_o),
    .countdown_result_o (countdown_result_o),
    .infected_nearby_o  (infected_nearby_o)
  );

endmodule

`default_nettype wire

// File: rtl/egcu_dpath.sv
`default_nettype none

module egcu_dpath import egcu_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [5:0]            row_i,
  input  wire logic [5:0]            column_i,
  input  wire logic [2:0]            cell_value_i,
  input  wire logic [7:0]            countdown_value_i,
  input  wire logic [6:0]            chance_draw_i,
  output logic [2:0]                 cell_result_o,
  output logic [7:0]                 countdown_result_o,
  output logic [5:0]                 infected_nearby_o
);

  localparam int unsigned CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] WIDTH_A   = ADDR_W'(MAX_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  // configuration
  logic [6:0] grid_width_q, grid_height_q;
  logic [1:0] proximity_q;
  logic [6:0] healthy_q, immune_q, death_q;
  logic [7:0] inf_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 7'd64;
      grid_height_q <= 7'd64;
      proximity_q   <= 2'd1;
      healthy_q     <= 7'd50;
      immune_q      <= 7'd10;
      death_q       <= 7'd10;
      inf_length_q  <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[6:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[6:0];
        CFG_PROXIMITY:   proximity_q   <= cfg_data_i[1:0];
        CFG_HEALTHY:     healthy_q     <= cfg_data_i[6:0];
        CFG_IMMUNE:      immune_q      <= cfg_data_i[6:0];
        CFG_DEATH:       death_q       <= cfg_data_i[6:0];
        CFG_INF_LENGTH:  inf_length_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request registers
  op_e        op_q;
  logic [5:0] row_q, col_q;
  logic [2:0] val_q;
  logic [7:0] cnt_q;
  logic [6:0] draw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(opcode_i);
      row_q  <= row_i;
      col_q  <= column_i;
      val_q  <= cell_value_i;
      cnt_q  <= countdown_value_i;
      draw_q <= chance_draw_i;
    end
  end

  logic              in_range;
  logic [ADDR_W-1:0] cell_addr;

  assign in_range  = (int'(row_q) < int'(MAX_HEIGHT)) && (int'(col_q) < int'(MAX_WIDTH));
  assign cell_addr = ADDR_W'(row_q) * WIDTH_A + ADDR_W'(col_q);

  // effective grid bounds and radius
  logic [6:0] w_eff, h_eff;
  logic [1:0] rad;
  logic signed [2:0] rad_s;

  assign w_eff = (int'(grid_width_q) > int'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : grid_width_q;
  assign h_eff = (int'(grid_height_q) > int'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height_q;
  assign rad   = (int'(proximity_q) > int'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : proximity_q;
  assign rad_s = $signed({1'b0, rad});

  // neighbourhood scan offsets
  logic signed [2:0] dr_q, dr_d, dc_q, dc_d;
  logic              scan_last;

  assign scan_last = (dr_q == rad_s) && (dc_q == rad_s);

  always_comb begin
    dr_d = dr_q;
    dc_d = dc_q;
    if (cmd_i.scan_init) begin
      dr_d = -rad_s;
      dc_d = -rad_s;
    end else if (cmd_i.scan_issue) begin
      if (dc_q == rad_s) begin
        dc_d = -rad_s;
        dr_d = dr_q + 3'sd1;
      end else begin
        dc_d = dc_q + 3'sd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q <= dr_d;
    dc_q <= dc_d;
  end

  logic signed [7:0] nr, nc;
  logic              nb_inside;
  logic [ADDR_W-1:0] nb_addr;

  assign nr = $signed({2'b00, row_q}) + $signed({{5{dr_q[2]}}, dr_q});
  assign nc = $signed({2'b00, col_q}) + $signed({{5{dc_q[2]}}, dc_q});
  assign nb_inside = !nr[7] && !nc[7] && (nr[6:0] < h_eff) && (nc[6:0] < w_eff)
                     && !((dr_q == 3'sd0) && (dc_q == 3'sd0));
  assign nb_addr = ADDR_W'(nr[6:0]) * WIDTH_A + ADDR_W'(nc[6:0]);

  // memories
  logic [2:0] cur_mem  [CELLS];
  logic [2:0] next_mem [CELLS];
  logic [7:0] cd_mem   [CELLS];

  logic [2:0]        cur_rd_q, next_rd_q;
  logic [7:0]        cd_rd_q;
  logic [ADDR_W-1:0] cur_raddr;

  assign cur_raddr = cmd_i.center_rd ? cell_addr : nb_addr;

  // commit sweep
  logic [ADDR_W-1:0] copy_addr_q, copy_wa_q;
  logic              copy_wr_q;
  logic              probe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_wr_q <= 1'b0;
      probe_q   <= 1'b0;
    end else begin
      copy_wr_q <= cmd_i.copy_issue;
      probe_q   <= cmd_i.scan_issue && nb_inside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_init) begin
      copy_addr_q <= '0;
    end else if (cmd_i.copy_issue) begin
      copy_addr_q <= copy_addr_q + ADDR_W'(1);
    end
    copy_wa_q <= copy_addr_q;
  end

  // update decision
  logic [2:0] st_q;
  logic [7:0] cd_q;
  logic [5:0] count_q;
  logic [2:0] nst;
  logic [7:0] ncd;
  logic [5:0] nnb;
  logic       cd_wr;
  logic [6:0] ch;

  always_comb begin
    nst   = st_q;
    ncd   = cd_q;
    nnb   = '0;
    cd_wr = 1'b0;
    ch    = (st_q == ST_HEALTHY) ? healthy_q : immune_q;
    case (st_q)
      ST_HEALTHY, ST_IMMUNE: begin
        nnb = count_q;
        if ((count_q != '0) && (draw_q < ch)) begin
          nst = ST_INFECTED;
        end
      end
      ST_INFECTED: begin
        nnb   = count_q;
        cd_wr = 1'b1;
        if (cd_q == '0) begin
          if (draw_q < death_q) begin
            nst = ST_DEAD;
          end else begin
            nst = ST_IMMUNE;
            ncd = inf_length_q;
          end
        end else begin
          ncd = cd_q - 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_rd_q  <= cur_mem[cur_raddr];
    cd_rd_q   <= cd_mem[cell_addr];
    next_rd_q <= next_mem[copy_addr_q];
    if (cmd_i.load_wr) begin
      cur_mem[cell_addr] <= val_q;
    end else if (copy_wr_q) begin
      cur_mem[copy_wa_q] <= next_rd_q;
    end
    if (cmd_i.load_wr || cmd_i.decide) begin
      next_mem[cell_addr] <= cmd_i.load_wr ? val_q : nst;
    end
    if (cmd_i.load_wr) begin
      cd_mem[cell_addr] <= cnt_q;
    end else if (cmd_i.decide && cd_wr) begin
      cd_mem[cell_addr] <= ncd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_center) begin
      st_q    <= cur_rd_q;
      cd_q    <= cd_rd_q;
      count_q <= '0;
    end else if (probe_q && (cur_rd_q == ST_INFECTED) && (count_q != COUNT_MAX)) begin
      count_q <= count_q + 6'd1;
    end
  end

  // result and output registers
  logic [2:0] res_cell_q, out_cell_q;
  logic [7:0] res_cd_q, out_cd_q;
  logic [5:0] res_nb_q, out_nb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_LOAD: begin
          res_cell_q <= val_q;
          res_cd_q   <= cnt_q;
          res_nb_q   <= '0;
        end
        RES_READ: begin
          res_cell_q <= cur_rd_q;
          res_cd_q   <= cd_rd_q;
          res_nb_q   <= '0;
        end
        RES_UPDATE: begin
          res_cell_q <= nst;
          res_cd_q   <= ncd;
          res_nb_q   <= nnb;
        end
        default: begin
          res_cell_q <= '0;
          res_cd_q   <= '0;
          res_nb_q   <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_cell_q <= res_cell_q;
      out_cd_q   <= res_cd_q;
      out_nb_q   <= res_nb_q;
    end
  end

  assign cell_result_o      = out_cell_q;
  assign countdown_result_o = out_cd_q;
  assign infected_nearby_o  = out_nb_q;

  assign sts_o.op        = op_q;
  assign sts_o.in_range  = in_range;
  assign sts_o.scan_last = scan_last;
  assign sts_o.copy_last = (copy_addr_q == LAST_ADDR);

  // a radius of at most three leaves at most 48 neighbours
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> (count_q <= 6'd48))
    else $error("neighbour count above 48");

  a_probe_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue && nb_inside |=> probe_q)
    else $error("in-grid neighbour read not counted");

endmodule

`default_nettype wire

// File: rtl/egcu_ctrl.sv
`default_nettype none

module egcu_ctrl import egcu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.op == OP_COMMIT) begin
          cmd_o.copy_init = 1'b1;
          state_d         = S_COPY;
        end else if (!sts_i.in_range) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ZERO;
          state_d        = S_FINISH;
        end else if (sts_i.op == OP_LOAD) begin
          cmd_o.load_wr  = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_LOAD;
          state_d        = S_FINISH;
        end else begin
          cmd_o.center_rd = 1'b1;
          state_d         = S_CENTER;
        end
      end
      S_CENTER: begin
        if (sts_i.op == OP_READ) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_READ;
          state_d        = S_FINISH;
        end else begin
          cmd_o.latch_center = 1'b1;
          cmd_o.scan_init    = 1'b1;
          state_d            = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide   = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_UPDATE;
        state_d        = S_FINISH;
      end
      S_COPY: begin
        cmd_o.copy_issue = 1'b1;
        if (sts_i.copy_last) begin
          state_d = S_COPY_DRAIN;
        end
      end
      S_COPY_DRAIN: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_ZERO;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) && out_valid_q && out_stall_i |=> (state_q == S_FINISH))
    else $error("finished result dropped while output stalled");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> (state_q == S_DISPATCH))
    else $error("accepted request not dispatched");

  a_scan_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && sts_i.scan_last |=> (state_q == S_DRAIN))
    else $error("scan did not end on last offset");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while held");

endmodule

`default_nettype wire

// File: dv/egcu_cell_checker.sv
`timescale 1ns / 100ps

// Watches the config port and both request/result channels, keeps its own copy of the
// grids, predicts one result per accepted request and compares in order.
module egcu_cell_checker import egcu_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [5:0]            row_i,
  input  wire logic [5:0]            column_i,
  input  wire logic [2:0]            cell_value_i,
  input  wire logic [7:0]            countdown_value_i,
  input  wire logic [6:0]            chance_draw_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire logic [2:0]            cell_result_i,
  input  wire logic [7:0]            countdown_result_i,
  input  wire logic [5:0]            infected_nearby_i,
  output int unsigned                fail_count_o,
  output int unsigned                waiting_o
);

  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    logic [2:0] state;
    logic [7:0] countdown;
    logic [5:0] nearby;
  } cell_res_t;

  logic [2:0] live_grid   [CELLS];
  logic [2:0] shadow_grid [CELLS];
  logic [7:0] timer_grid  [CELLS];

  logic [6:0] width_q, height_q;
  logic [1:0] radius_q;
  logic [6:0] healthy_pct, immune_pct, death_pct;
  logic [7:0] reload_len;

  cell_res_t   cell_results_q[$];
  int unsigned fails;
  int unsigned waiting;

  assign fail_count_o = fails;
  assign waiting_o    = waiting;

  // infected cells in the radius square, clipped to the configured grid
  function automatic logic [5:0] infected_around(int r, int c);
    int w, h, rad, n, dr, dc, nr, nc;
    w   = (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
    h   = (height_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q);
    rad = (radius_q > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
    n   = 0;
    for (dr = -rad; dr <= rad; dr++) begin
      for (dc = -rad; dc <= rad; dc++) begin
        nr = r + dr;
        nc = c + dc;
        if (!(dr == 0 && dc == 0) && nr >= 0 && nc >= 0 && nr < h && nc < w) begin
          if (live_grid[nr * MAX_WIDTH + nc] == ST_INFECTED) n++;
        end
      end
    end
    return (n > 63) ? 6'd63 : 6'(n);
  endfunction

  function automatic cell_res_t evolve_cell(op_e op, logic [5:0] row, logic [5:0] col,
                                            logic [2:0] val, logic [7:0] cnt,
                                            logic [6:0] draw);
    cell_res_t  res;
    int         a, i;
    logic [2:0] st;
    logic [7:0] cd;
    logic [6:0] pct;
    res = '0;
    if (op == OP_COMMIT) begin
      for (i = 0; i < CELLS; i++) live_grid[i] = shadow_grid[i];
      return res;
    end
    if (row >= MAX_HEIGHT || col >= MAX_WIDTH) return res;
    a = row * MAX_WIDTH + col;
    case (op)
      OP_LOAD: begin
        live_grid[a]   = val;
        shadow_grid[a] = val;
        timer_grid[a]  = cnt;
        res.state      = val;
        res.countdown  = cnt;
      end
      OP_READ: begin
        res.state     = live_grid[a];
        res.countdown = timer_grid[a];
      end
      default: begin
        st = live_grid[a];
        cd = timer_grid[a];
        if (st == ST_HEALTHY || st == ST_IMMUNE) begin
          pct        = (st == ST_HEALTHY) ? healthy_pct : immune_pct;
          res.nearby = infected_around(row, col);
          if (res.nearby != 0 && draw < pct) st = ST_INFECTED;
        end else if (st == ST_INFECTED) begin
          res.nearby = infected_around(row, col);
          if (cd == 0) begin
            if (draw < death_pct) begin
              st = ST_DEAD;
            end else begin
              st = ST_IMMUNE;
              cd = reload_len;
            end
          end else begin
            cd = cd - 8'd1;
          end
          timer_grid[a] = cd;
        end
        shadow_grid[a] = st;
        res.state      = st;
        res.countdown  = cd;
      end
    endcase
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_res_t want;
    if (!rst_ni) begin
      width_q     <= 7'd64;
      height_q    <= 7'd64;
      radius_q    <= 2'd1;
      healthy_pct <= 7'd50;
      immune_pct  <= 7'd10;
      death_pct   <= 7'd10;
      reload_len  <= 8'd10;
      cell_results_q.delete();
      fails   = 0;
      waiting = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cell_results_q.size() == 0) begin
          report_error($sformatf("result %0d/%0d/%0d with no request waiting",
                                 cell_result_i, countdown_result_i, infected_nearby_i));
        end else begin
          want = cell_results_q.pop_front();
          if (cell_result_i !== want.state)
            report_error($sformatf("cell_result: expected %0d got %0d",
                                   want.state, cell_result_i));
          if (countdown_result_i !== want.countdown)
            report_error($sformatf("countdown_result: expected %0d got %0d",
                                   want.countdown, countdown_result_i));
          if (infected_nearby_i !== want.nearby)
            report_error($sformatf("infected_nearby: expected %0d got %0d",
                                   want.nearby, infected_nearby_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        cell_results_q.push_back(evolve_cell(op_e'(opcode_i), row_i, column_i, cell_value_i,
                                             countdown_value_i, chance_draw_i));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_WIDTH:  width_q     <= cfg_data_i[6:0];
          CFG_GRID_HEIGHT: height_q    <= cfg_data_i[6:0];
          CFG_PROXIMITY:   radius_q    <= cfg_data_i[1:0];
          CFG_HEALTHY:     healthy_pct <= cfg_data_i[6:0];
          CFG_IMMUNE:      immune_pct  <= cfg_data_i[6:0];
          CFG_DEATH:       death_pct   <= cfg_data_i[6:0];
          CFG_INF_LENGTH:  reload_len  <= cfg_data_i;
          default: ;
        endcase
      end
      waiting = cell_results_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import egcu_pkg::*;

  localparam int unsigned MAX_W = 64;
  localparam int unsigned MAX_H = 64;
  localparam int unsigned MAX_R = 3;

  // written square in the top-left corner; addressed cells keep their whole radius inside it
  localparam int unsigned AREA = 20;
  localparam int unsigned SAFE = AREA - MAX_R;

  // A commit sweeps all cells with no handshake going through; this limit leaves ample margin.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // the longest update is the one at full radius
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned SEGMENT_ITEMS  = 180;
  localparam int unsigned NUM_SEGMENTS   = 6;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [1:0]            opcode      = '0;
  logic [5:0]            row         = '0;
  logic [5:0]            column      = '0;
  logic [2:0]            cell_value  = '0;
  logic [7:0]            countdown   = '0;
  logic [6:0]            chance_draw = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            cell_result;
  logic [7:0]            countdown_result;
  logic [5:0]            infected_nearby;

  int unsigned           fail_count;
  int unsigned           waiting;

  // idle percentages for the two sides, switched per segment
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;

  // mirror of the grid size in use, to aim request windows at the live area
  int unsigned           span_w = MAX_W;
  int unsigned           span_h = MAX_H;

  int unsigned           quiet_cycles = 0;

  always #5 clk = ~clk;

  epidemic_grid_cell_update #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .MAX_RADIUS (MAX_R)
  ) uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .opcode_i           (opcode),
    .row_i              (row),
    .column_i           (column),
    .cell_value_i       (cell_value),
    .countdown_value_i  (countdown),
    .chance_draw_i      (chance_draw),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .cell_result_o      (cell_result),
    .countdown_result_o (countdown_result),
    .infected_nearby_o  (infected_nearby)
  );

  egcu_cell_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .MAX_RADIUS (MAX_R)
  ) u_cell_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .opcode_i           (opcode),
    .row_i              (row),
    .column_i           (column),
    .cell_value_i       (cell_value),
    .countdown_value_i  (countdown),
    .chance_draw_i      (chance_draw),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .cell_result_i      (cell_result),
    .countdown_result_i (countdown_result),
    .infected_nearby_i  (infected_nearby),
    .fail_count_o       (fail_count),
    .waiting_o          (waiting)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: cycles in which no request, result or register write goes through
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Mostly the states that interact, with the odd unused encoding (5..7) mixed in.
  function automatic logic [2:0] pick_state();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return ST_HEALTHY;
    if (r < 55) return ST_INFECTED;
    if (r < 75) return ST_IMMUNE;
    if (r < 85) return ST_EMPTY;
    if (r < 95) return ST_DEAD;
    return 3'($urandom_range(7, 5));
  endfunction

  // small countdowns half the time so infected cells reach zero quickly
  function automatic logic [7:0] pick_timer();
    return $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  // Valid stays high on return so back-to-back requests see no gap.
  task automatic send_req(op_e op, logic [5:0] r, logic [5:0] c, logic [2:0] val,
                          logic [7:0] cnt, logic [6:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    row         <= r;
    column      <= c;
    cell_value  <= val;
    countdown   <= cnt;
    chance_draw <= draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // only called with the block idle
  task automatic program_grid(logic [7:0] w, logic [7:0] h, logic [7:0] prox,
                              logic [7:0] hc, logic [7:0] ic, logic [7:0] dc,
                              logic [7:0] il);
    write_reg(CFG_GRID_WIDTH,  w);
    write_reg(CFG_GRID_HEIGHT, h);
    write_reg(CFG_PROXIMITY,   prox);
    write_reg(CFG_HEALTHY,     hc);
    write_reg(CFG_IMMUNE,      ic);
    write_reg(CFG_DEATH,       dc);
    write_reg(CFG_INF_LENGTH,  il);
    cfg_we <= 1'b0;
    span_w = (w[6:0] > MAX_W) ? MAX_W : w[6:0];
    span_h = (h[6:0] > MAX_H) ? MAX_H : h[6:0];
  endtask

  // Random traffic. Most of it is generation sweeps: update a small window, sometimes
  // commit, then read back. The rest is loose loads, reads, the odd commit and stray update.
  task automatic run_segment(int unsigned n_items);
    int unsigned sent, pick, lim_r, lim_c, top_r, top_c, len_r, len_c, i, j;
    sent  = 0;
    lim_r = (span_h + 2 > SAFE) ? SAFE : span_h + 2;
    lim_c = (span_w + 2 > SAFE) ? SAFE : span_w + 2;
    while (sent < n_items) begin
      pick  = $urandom_range(99);
      top_r = $urandom_range(lim_r - 1);
      top_c = $urandom_range(lim_c - 1);
      if (pick < 60) begin
        len_r = $urandom_range(4, 1);
        len_c = $urandom_range(4, 1);
        for (i = 0; i < len_r; i++) begin
          for (j = 0; j < len_c; j++) begin
            if (top_r + i < SAFE && top_c + j < SAFE) begin
              send_req(OP_UPDATE, 6'(top_r + i), 6'(top_c + j), 3'($urandom),
                       8'($urandom), 7'($urandom_range(99)));
              sent++;
            end
          end
        end
        if ($urandom_range(99) < 40) begin
          send_req(OP_COMMIT, 6'($urandom), 6'($urandom), 3'($urandom), 8'($urandom),
                   7'($urandom_range(99)));
          sent++;
        end
        send_req(OP_READ, 6'(top_r), 6'(top_c), 3'($urandom), 8'($urandom),
                 7'($urandom_range(99)));
        sent++;
      end else if (pick < 80) begin
        // loads land mostly in the live area to keep infections going
        if ($urandom_range(99) < 30) begin
          top_r = $urandom_range(AREA - 1);
          top_c = $urandom_range(AREA - 1);
        end
        send_req(OP_LOAD, 6'(top_r), 6'(top_c), pick_state(), pick_timer(),
                 7'($urandom_range(99)));
        sent++;
      end else if (pick < 95) begin
        send_req(OP_READ, 6'($urandom_range(SAFE - 1)), 6'($urandom_range(SAFE - 1)),
                 3'($urandom), 8'($urandom), 7'($urandom_range(99)));
        sent++;
      end else if (pick < 97) begin
        send_req(OP_COMMIT, 6'($urandom), 6'($urandom), 3'($urandom), 8'($urandom),
                 7'($urandom_range(99)));
        sent++;
      end else begin
        send_req(OP_UPDATE, 6'($urandom_range(SAFE - 1)), 6'($urandom_range(SAFE - 1)),
                 3'($urandom), 8'($urandom), 7'($urandom_range(99)));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned r, c, seg;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 53;

    // Grid memories come up undefined; every cell that is read or counted as a neighbor
    // is written first: a square in the top-left corner and a patch in the bottom-right.
    for (r = 0; r < AREA; r++) begin
      for (c = 0; c < AREA; c++) begin
        send_req(OP_LOAD, 6'(r), 6'(c), pick_state(), pick_timer(), 7'($urandom_range(99)));
      end
    end
    for (r = MAX_H - 4; r < MAX_H; r++) begin
      for (c = MAX_W - 4; c < MAX_W; c++) begin
        send_req(OP_LOAD, 6'(r), 6'(c), pick_state(), pick_timer(), 7'($urandom_range(99)));
      end
    end

    // Directed requests, reset register values in force.
    send_req(OP_READ,   6'd0,  6'd0,  3'd0,        8'd0,   7'd0);
    // top-left corner: healthy cell caught by an infected neighbor
    send_req(OP_LOAD,   6'd0,  6'd0,  ST_HEALTHY,  8'd0,   7'd0);
    send_req(OP_LOAD,   6'd0,  6'd1,  ST_INFECTED, 8'd0,   7'd0);
    send_req(OP_UPDATE, 6'd0,  6'd0,  3'd0,        8'd0,   7'd0);
    // timer at zero, draw misses death chance: recovers with countdown reloaded
    send_req(OP_UPDATE, 6'd0,  6'd1,  3'd0,        8'd0,   7'd99);
    // timer at zero, draw hits: dies, countdown stays zero
    send_req(OP_LOAD,   6'd1,  6'd1,  ST_INFECTED, 8'd0,   7'd0);
    send_req(OP_UPDATE, 6'd1,  6'd1,  3'd0,        8'd0,   7'd0);
    // bottom-right corner, timer at max counts down
    send_req(OP_LOAD,   6'd63, 6'd63, ST_INFECTED, 8'd255, 7'd0);
    send_req(OP_UPDATE, 6'd63, 6'd63, 3'd7,        8'd255, 7'd42);
    // immune cell reinfected next to it
    send_req(OP_LOAD,   6'd63, 6'd62, ST_IMMUNE,   8'd7,   7'd0);
    send_req(OP_UPDATE, 6'd63, 6'd62, 3'd0,        8'd0,   7'd0);
    // exposed healthy cell, draw too high to infect
    send_req(OP_LOAD,   6'd62, 6'd62, ST_HEALTHY,  8'd3,   7'd0);
    send_req(OP_UPDATE, 6'd62, 6'd62, 3'd0,        8'd0,   7'd99);
    // unused state encodings pass through with their countdown
    send_req(OP_LOAD,   6'd32, 6'd32, 3'd5,        8'd128, 7'd0);
    send_req(OP_UPDATE, 6'd32, 6'd32, 3'd0,        8'd0,   7'd0);
    send_req(OP_LOAD,   6'd32, 6'd33, 3'd7,        8'd1,   7'd0);
    send_req(OP_UPDATE, 6'd32, 6'd33, 3'd0,        8'd0,   7'd0);
    // empty and dead are left alone
    send_req(OP_LOAD,   6'd10, 6'd10, ST_EMPTY,    8'd200, 7'd0);
    send_req(OP_UPDATE, 6'd10, 6'd10, 3'd0,        8'd0,   7'd0);
    send_req(OP_LOAD,   6'd10, 6'd11, ST_DEAD,     8'd9,   7'd0);
    send_req(OP_UPDATE, 6'd10, 6'd11, 3'd0,        8'd0,   7'd0);
    send_req(OP_COMMIT, 6'd63, 6'd0,  3'd7,        8'd255, 7'd99);
    send_req(OP_READ,   6'd0,  6'd0,  3'd0,        8'd0,   7'd0);
    send_req(OP_READ,   6'd63, 6'd63, 3'd0,        8'd0,   7'd0);

    for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
      wait_drained();
      case (seg)
        0: program_grid(8'd127, 8'd64, 8'd3, 8'd100, 8'd0, 8'd0, 8'd255); // oversize, max radius
        1: program_grid(8'd64, 8'd1, 8'd0, 8'd127, 8'd127, 8'd100, 8'd0); // radius 0, one row
        2: program_grid(8'd0, 8'd0, 8'd2, 8'd50, 8'd50, 8'd50, 8'd1);     // empty grid size
        3: program_grid(8'($urandom_range(16, 1)), 8'($urandom_range(16, 1)),
                        8'($urandom_range(3)), 8'($urandom_range(127)),
                        8'($urandom_range(127)), 8'($urandom_range(127)), 8'($urandom));
        4: program_grid(8'($urandom_range(64, 1)), 8'($urandom_range(64, 1)),
                        8'($urandom_range(3)), 8'($urandom_range(100)),
                        8'($urandom_range(100)), 8'($urandom_range(100)), 8'($urandom));
        default: program_grid(8'($urandom_range(127, 1)), 8'($urandom_range(127, 1)),
                              8'($urandom_range(3)), 8'($urandom_range(127)),
                              8'($urandom_range(127)), 8'($urandom_range(127)),
                              8'($urandom));
      endcase
      // idle mix: sender-heavy pair, then swapped, then full throughput
      if (seg < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 53;
      end else if (seg < 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_segment(SEGMENT_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
